// ===== rtl/gpcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpcsm_pkg
// Shared types, sizes and codes of the path cost stamp map.
// ----------------------------------------------------------------------------
package gpcsm_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int COST_BITS   = 16;
   localparam int DIM_BITS    = 9;
   localparam int POS_BITS    = 10;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int PROD_BITS   = ROW_BITS + DIM_BITS;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef logic signed [COST_BITS-1:0] cost_type;
   typedef logic signed [POS_BITS-1:0]  pos_type;
   typedef logic [DIM_BITS-1:0]         dim_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;
   typedef logic [1:0]                  mode_type;
   typedef logic [CSR_IDX_BITS-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0]    csr_data_type;
   typedef logic [2:0]                  step_type;

   localparam mode_type MODE_CLEAR = 2'd0;
   localparam mode_type MODE_MARK  = 2'd1;
   localparam mode_type MODE_QUERY = 2'd2;

   localparam csr_idx_type CSR_GRID_COLS      = 2'd0;
   localparam csr_idx_type CSR_GRID_ROWS      = 2'd1;
   localparam csr_idx_type CSR_COST_ON_PATH   = 2'd2;
   localparam csr_idx_type CSR_COST_NEAR_PATH = 2'd3;

   // step 0 is the path point, steps 1..4 its neighbours +x, +y, -x, -y
   localparam step_type STEP_CENTER = 3'd0;
   localparam step_type STEP_LAST   = 3'd4;

   typedef struct packed {
      logic     hit;
      addr_type addr;
   } cell_ref_type;

   function automatic pos_type step_dx(input step_type step);
      pos_type d;
      case (step)
         3'd1:    d = pos_type'(1);
         3'd3:    d = pos_type'(-1);
         default: d = pos_type'(0);
      endcase
      return d;
   endfunction

   function automatic pos_type step_dy(input step_type step);
      pos_type d;
      case (step)
         3'd2:    d = pos_type'(1);
         3'd4:    d = pos_type'(-1);
         default: d = pos_type'(0);
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/gpcsm_addr_unit.sv =====
// ----------------------------------------------------------------------------
// gpcsm_addr_unit
// Map bounds check and flat cell address (row * width + column), registered.
// ----------------------------------------------------------------------------
module gpcsm_addr_unit (
   input  logic                    clock,
   input  gpcsm_pkg::pos_type      pos_x,
   input  gpcsm_pkg::pos_type      pos_y,
   input  gpcsm_pkg::dim_type      grid_cols,
   input  gpcsm_pkg::dim_type      grid_rows,
   output gpcsm_pkg::cell_ref_type cell_ref
);
   import gpcsm_pkg::*;

   dim_type                eff_w;
   dim_type                eff_h;
   logic [POS_BITS-1:0]    ux;
   logic [POS_BITS-1:0]    uy;
   logic                   in_map;
   logic [PROD_BITS-1:0]   prod;
   logic [PROD_BITS-1:0]   sum;
   cell_ref_type           cell_ref_ff;

   assign eff_w = (grid_cols > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : grid_cols;
   assign eff_h = (grid_rows > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : grid_rows;

   assign ux = pos_x;
   assign uy = pos_y;

   assign in_map = !pos_x[POS_BITS-1] && !pos_y[POS_BITS-1]
                   && (ux < POS_BITS'(eff_w)) && (uy < POS_BITS'(eff_h));

   assign prod = PROD_BITS'(uy[ROW_BITS-1:0]) * PROD_BITS'(eff_w);
   assign sum  = prod + PROD_BITS'(ux[COL_BITS-1:0]);

   always_ff @(posedge clock) begin
      cell_ref_ff.hit  <= in_map;
      cell_ref_ff.addr <= sum[ADDR_BITS-1:0];
   end

   assign cell_ref = cell_ref_ff;

endmodule

// ===== rtl/grid_path_cost_stamp_map.sv =====
// ----------------------------------------------------------------------------
// grid_path_cost_stamp_map
// Grid of signed extra-cost cells: clear, stamp a path point, query a cell.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_mode, req_pos_x, req_pos_y
//  rsp      out        rsp_valid/rsp_stall  rsp_cell_cost
//  csr      in         csr_wr_en            csr_index, csr_wr_data
//
//  One shared address unit (multiply-add, bounds check) and one cell RAM
//  port, run by a sequencer. Query: address, read, post the result. Mark:
//  address and write the point, then address and read-modify-write each
//  neighbor, then post the result. Clear writes every cell, then posts. The
//  sequencer returns to idle before the next item is taken.
//  After reset a clearing pass over every cell runs before the first item.
//  A result waits in the output register; the next item is taken meanwhile,
//  and only a finished item whose result cannot be placed waits for rsp.
// ----------------------------------------------------------------------------
module grid_path_cost_stamp_map (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gpcsm_pkg::mode_type     req_mode,
   input  gpcsm_pkg::pos_type      req_pos_x,
   input  gpcsm_pkg::pos_type      req_pos_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output gpcsm_pkg::cost_type     rsp_cell_cost,
   input  logic                    csr_wr_en,
   input  gpcsm_pkg::csr_idx_type  csr_index,
   input  gpcsm_pkg::csr_data_type csr_wr_data
);
   import gpcsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADDR,
      ST_LOOK,
      ST_UPDATE,
      ST_RESP
   } state_type;

   state_type    state_ff;
   logic         init_ff;
   addr_type     clr_cnt_ff;
   step_type     step_ff;
   mode_type     mode_ff;
   pos_type      base_x_ff;
   pos_type      base_y_ff;
   cost_type     result_ff;
   logic         rsp_valid_ff;
   cost_type     rsp_cost_ff;

   dim_type      cols_ff;
   dim_type      rows_ff;
   cost_type     on_path_ff;
   cost_type     near_path_ff;

   pos_type      cur_x;
   pos_type      cur_y;
   cell_ref_type cell_ref;

   cost_type     mem [STORE_DEPTH];
   cost_type     rd_data_ff;
   logic         mem_we;
   logic         mem_re;
   addr_type     mem_addr;
   cost_type     mem_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= '0;
         rows_ff      <= '0;
         on_path_ff   <= '0;
         near_path_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_COLS:      cols_ff      <= csr_wr_data[DIM_BITS-1:0];
            CSR_GRID_ROWS:      rows_ff      <= csr_wr_data[DIM_BITS-1:0];
            CSR_COST_ON_PATH:   on_path_ff   <= cost_type'(csr_wr_data[COST_BITS-1:0]);
            CSR_COST_NEAR_PATH: near_path_ff <= cost_type'(csr_wr_data[COST_BITS-1:0]);
            default: ;
         endcase
      end
   end

   assign cur_x = base_x_ff + step_dx(step_ff);
   assign cur_y = base_y_ff + step_dy(step_ff);

   gpcsm_addr_unit u_addr (
      .clock     (clock),
      .pos_x     (cur_x),
      .pos_y     (cur_y),
      .grid_cols (cols_ff),
      .grid_rows (rows_ff),
      .cell_ref  (cell_ref)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = cell_ref.addr;
      mem_wdata = on_path_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = '0;
         end
         ST_LOOK: begin
            if (cell_ref.hit) begin
               if (step_ff == STEP_CENTER && mode_ff == MODE_MARK) begin
                  mem_we = 1'b1;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            mem_wdata = near_path_ff;
            if (mode_ff == MODE_MARK && rd_data_ff > near_path_ff) begin
               mem_we = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         step_ff      <= STEP_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff != ST_RESP && rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff    <= req_mode;
                  base_x_ff  <= req_pos_x;
                  base_y_ff  <= req_pos_y;
                  result_ff  <= '0;
                  step_ff    <= STEP_CENTER;
                  clr_cnt_ff <= '0;
                  case (req_mode)
                     MODE_CLEAR: state_ff <= ST_CLEAR;
                     MODE_MARK:  state_ff <= ST_ADDR;
                     MODE_QUERY: state_ff <= ST_ADDR;
                     default:    state_ff <= ST_RESP;
                  endcase
               end
            end
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
                  init_ff  <= 1'b0;
                  state_ff <= init_ff ? ST_IDLE : ST_RESP;
               end
            end
            ST_ADDR: begin
               state_ff <= ST_LOOK;
            end
            ST_LOOK: begin
               if (!cell_ref.hit) begin
                  if (step_ff == STEP_CENTER || step_ff == STEP_LAST) begin
                     state_ff <= ST_RESP;
                  end else begin
                     step_ff  <= step_ff + 1'b1;
                     state_ff <= ST_ADDR;
                  end
               end else if (step_ff == STEP_CENTER && mode_ff == MODE_MARK) begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_ADDR;
               end else begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (mode_ff == MODE_QUERY) begin
                  result_ff <= rd_data_ff;
                  state_ff  <= ST_RESP;
               end else if (step_ff == STEP_LAST) begin
                  state_ff <= ST_RESP;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_ADDR;
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cost_ff  <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_cost = rsp_cost_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response state");

   a_update_after_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(state_ff == ST_LOOK) && $past(mem_re))
      else $error("cell update without a preceding read");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("cell RAM read and written in the same cycle");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST)
      else $error("neighbor step out of range");

endmodule

// ===== tb/tb_grid_path_cost_stamp_map.sv =====
// ----------------------------------------------------------------------------
// tb_grid_path_cost_stamp_map
// Self-checking bench for the path cost stamp map. A short table of directed
// items (empty map, corners, outside points, cost extremes, oversized map,
// resize without clear, clear) is followed by randomized segments. Each
// segment reprograms the map size and costs and runs one idle/stall profile.
// Every accepted item is run through a local model of the grid, and each
// result is compared in order against the expected cost.
// ----------------------------------------------------------------------------
module tb_grid_path_cost_stamp_map;
   import gpcsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam mode_type MODE_UNUSED  = 2'd3;
   localparam int       DRAIN_CYCLES = 20;
   localparam int       HOLD_CYCLES  = 400;
   localparam int       SEGMENTS     = 8;
   localparam int       SEG_ITEMS    = 112;

   typedef struct packed {
      logic         is_csr;
      mode_type     mode;
      pos_type      x;
      pos_type      y;
      logic         typed;
      cost_type     want;
      csr_idx_type  idx;
      csr_data_type data;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   mode_type     req_mode;
   pos_type      req_pos_x;
   pos_type      req_pos_y;
   logic         rsp_valid;
   logic         rsp_stall;
   cost_type     rsp_cell_cost;
   logic         csr_wr_en;
   csr_idx_type  csr_index;
   csr_data_type csr_wr_data;

   // typed expectation travels with the item
   logic         req_typed;
   cost_type     req_want;

   cost_type     grid_cells [0:STORE_DEPTH-1];
   int           grid_w;
   int           grid_h;
   cost_type     on_cost;
   cost_type     near_cost;
   cost_type     cost_due [$];
   stim_row_type dir_rows [$];

   int           errors;
   int           n_items;
   int           n_marks;
   int           n_queries;
   int           n_clears;
   int           n_checked;
   int           send_pct;
   int           idle_pct;
   int           stall_pct;
   int           hold_gen;

   grid_path_cost_stamp_map u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_cost (rsp_cell_cost),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #80ms;
      $display("%0t: timeout, %0d results still due", $time, cost_due.size());
      $display("[grid_path_cost_stamp_map] ERROR");
      $finish;
   end

   function automatic bit on_grid(input int x, input int y, input int ew, input int eh);
      return x >= 0 && y >= 0 && x < ew && y < eh;
   endfunction

   function automatic cost_type stamp_predict(input mode_type m, input pos_type px,
                                              input pos_type py);
      int       x;
      int       y;
      int       nx;
      int       ny;
      int       ew;
      int       eh;
      cost_type res;
      res = '0;
      x   = px;
      y   = py;
      ew  = (grid_w > MAX_WIDTH) ? MAX_WIDTH : grid_w;
      eh  = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : grid_h;
      case (m)
         MODE_CLEAR: begin
            for (int a = 0; a < STORE_DEPTH; a++) grid_cells[a] = '0;
         end
         MODE_MARK: begin
            if (on_grid(x, y, ew, eh)) begin
               grid_cells[y * ew + x] = on_cost;
               // neighbors in the order +x, +y, -x, -y
               for (int k = 0; k < 4; k++) begin
                  nx = x + ((k == 0) ? 1 : (k == 2) ? -1 : 0);
                  ny = y + ((k == 1) ? 1 : (k == 3) ? -1 : 0);
                  if (on_grid(nx, ny, ew, eh) && grid_cells[ny * ew + nx] > near_cost)
                     grid_cells[ny * ew + nx] = near_cost;
               end
            end
         end
         MODE_QUERY: begin
            if (on_grid(x, y, ew, eh)) res = grid_cells[y * ew + x];
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   // item side: predict on acceptance, shadow the registers
   always @(posedge clock) begin : item_mon
      cost_type pred;
      if (!reset && csr_wr_en) begin
         case (csr_index)
            CSR_GRID_COLS:      grid_w    = int'(csr_wr_data[DIM_BITS-1:0]);
            CSR_GRID_ROWS:      grid_h    = int'(csr_wr_data[DIM_BITS-1:0]);
            CSR_COST_ON_PATH:   on_cost   = cost_type'(csr_wr_data);
            CSR_COST_NEAR_PATH: near_cost = cost_type'(csr_wr_data);
            default: ;
         endcase
      end
      if (!reset && req_valid && !req_stall) begin
         pred = stamp_predict(req_mode, req_pos_x, req_pos_y);
         cost_due.push_back(req_typed ? req_want : pred);
         n_items++;
         case (req_mode)
            MODE_MARK:  n_marks++;
            MODE_QUERY: n_queries++;
            MODE_CLEAR: n_clears++;
            default: ;
         endcase
      end
   end

   // result side
   always @(posedge clock) begin : rsp_mon
      cost_type exp_cost;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cost_due.size() == 0) begin
            $display("%0t: result with nothing expected, got %0d", $time, rsp_cell_cost);
            errors++;
         end else begin
            exp_cost = cost_due.pop_front();
            n_checked++;
            if (rsp_cell_cost !== exp_cost) begin
               $display("%0t: cell_cost mismatch, expected %0d, got %0d",
                        $time, exp_cost, rsp_cell_cost);
               errors++;
            end
         end
      end
   end

   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_gen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic void add_item(input mode_type m, input int x, input int y,
                                    input logic typed, input int want);
      stim_row_type r;
      r        = '0;
      r.mode   = m;
      r.x      = pos_type'(x);
      r.y      = pos_type'(y);
      r.typed  = typed;
      r.want   = cost_type'(want);
      dir_rows.push_back(r);
   endfunction

   function automatic void add_csr(input csr_idx_type idx, input int data);
      stim_row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.data   = csr_data_type'(data);
      dir_rows.push_back(r);
   endfunction

   function automatic cost_type pick_cost();
      cost_type c;
      case ($urandom_range(7))
         0:       c = cost_type'(-32768);
         1:       c = cost_type'(32767);
         2:       c = '0;
         default: c = cost_type'($urandom);
      endcase
      return c;
   endfunction

   task automatic send_item(input mode_type m, input pos_type x, input pos_type y,
                            input logic typed, input cost_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_pos_x <= x;
      req_pos_y <= y;
      req_typed <= typed;
      req_want  <= want;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cost_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_data_type data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int       w;
      int       h;
      int       ew;
      int       eh;
      int       pick;
      int       clears_left;
      int       last_x;
      int       last_y;
      bit       have_mark;
      int       xi;
      int       yi;
      mode_type m;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = MODE_CLEAR;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_typed   = 1'b0;
      req_want    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_GRID_COLS;
      csr_wr_data = '0;
      errors      = 0;
      n_items     = 0;
      n_marks     = 0;
      n_queries   = 0;
      n_clears    = 0;
      n_checked   = 0;
      send_pct    = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_gen    = 0;
      grid_w      = 0;
      grid_h      = 0;
      on_cost     = '0;
      near_cost   = '0;
      for (int a = 0; a < STORE_DEPTH; a++) grid_cells[a] = '0;

      // empty map after reset
      add_item(MODE_QUERY, 0, 0, 1'b1, 0);
      add_item(MODE_MARK, 0, 0, 1'b1, 0);
      add_item(MODE_UNUSED, -512, 511, 1'b1, 0);
      // small map: center, corners, outside points
      add_csr(CSR_GRID_COLS, 4);
      add_csr(CSR_GRID_ROWS, 3);
      add_csr(CSR_COST_ON_PATH, 100);
      add_csr(CSR_COST_NEAR_PATH, -7);
      add_item(MODE_MARK, 1, 1, 1'b0, 0);
      add_item(MODE_QUERY, 1, 1, 1'b0, 0);
      add_item(MODE_QUERY, 2, 1, 1'b0, 0);
      add_item(MODE_MARK, 0, 0, 1'b0, 0);
      add_item(MODE_MARK, 3, 2, 1'b0, 0);
      add_item(MODE_MARK, 4, 0, 1'b0, 0);
      add_item(MODE_MARK, -1, 2, 1'b0, 0);
      add_item(MODE_QUERY, 3, 1, 1'b0, 0);
      add_item(MODE_QUERY, -1, 0, 1'b1, 0);
      add_item(MODE_QUERY, 4, 2, 1'b1, 0);
      // cost extremes
      add_csr(CSR_COST_ON_PATH, -32768);
      add_csr(CSR_COST_NEAR_PATH, 32767);
      add_item(MODE_MARK, 2, 1, 1'b0, 0);
      add_item(MODE_QUERY, 1, 1, 1'b0, 0);
      add_csr(CSR_COST_ON_PATH, 32767);
      add_csr(CSR_COST_NEAR_PATH, -32768);
      add_item(MODE_MARK, 2, 2, 1'b0, 0);
      add_item(MODE_QUERY, 2, 1, 1'b0, 0);
      add_item(MODE_QUERY, 2, 2, 1'b0, 0);
      // narrower map over old contents
      add_csr(CSR_GRID_COLS, 2);
      add_item(MODE_QUERY, 1, 1, 1'b0, 0);
      // oversized map saturates
      add_csr(CSR_GRID_COLS, 511);
      add_csr(CSR_GRID_ROWS, 511);
      add_item(MODE_MARK, 255, 255, 1'b0, 0);
      add_item(MODE_QUERY, 255, 255, 1'b0, 0);
      add_item(MODE_QUERY, 256, 0, 1'b1, 0);
      add_item(MODE_QUERY, 0, 256, 1'b1, 0);
      add_item(MODE_QUERY, 511, -512, 1'b1, 0);
      add_csr(CSR_GRID_COLS, 256);
      add_csr(CSR_GRID_ROWS, 0);
      add_item(MODE_QUERY, 0, 0, 1'b1, 0);
      add_csr(CSR_GRID_ROWS, 256);
      add_item(MODE_CLEAR, 0, 0, 1'b1, 0);
      add_item(MODE_QUERY, 255, 255, 1'b1, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            wait_idle();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_item(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y,
                      dir_rows[i].typed, dir_rows[i].want);
         end
      end

      clears_left = 4;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         case (seg % 4)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 82; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 82; end
            default: begin send_pct = 17; stall_pct = 17; end
         endcase
         case (seg)
            2: begin w = 511; h = 511; end
            5: begin w = 256; h = 1; end
            default: begin
               pick = $urandom_range(9);
               if (pick < 6) begin
                  w = $urandom_range(8, 1);
                  h = $urandom_range(8, 1);
               end else if (pick < 8) begin
                  w = $urandom_range(40, 1);
                  h = $urandom_range(40, 1);
               end else if (pick < 9) begin
                  w = $urandom_range(511, 200);
                  h = $urandom_range(511, 200);
               end else begin
                  w = $urandom_range(1) ? 0 : $urandom_range(8, 1);
                  h = (w == 0) ? $urandom_range(8, 1) : 0;
               end
            end
         endcase
         write_reg(CSR_GRID_COLS, {7'($urandom), 9'(w)});
         write_reg(CSR_GRID_ROWS, {7'($urandom), 9'(h)});
         write_reg(CSR_COST_ON_PATH, csr_data_type'(pick_cost()));
         write_reg(CSR_COST_NEAR_PATH, csr_data_type'(pick_cost()));
         ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
         eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
         have_mark = 1'b0;
         last_x = 0;
         last_y = 0;
         if (seg == 1) hold_gen++;

         for (int n = 0; n < SEG_ITEMS; n++) begin
            idle_pct = (seg == 1 && n < 24) ? 0 : send_pct;
            if (seg == 3 && n == SEG_ITEMS / 2) wait_idle();
            pick = $urandom_range(99);
            if (pick < 46)      m = MODE_MARK;
            else if (pick < 94) m = MODE_QUERY;
            else if (pick < 99) m = MODE_UNUSED;
            else                m = (clears_left > 0) ? MODE_CLEAR : MODE_QUERY;
            if (m == MODE_CLEAR) clears_left--;
            pick = $urandom_range(99);
            if (pick < 12 || ew == 0 || eh == 0) begin
               xi = int'(pos_type'($urandom));
               yi = int'(pos_type'($urandom));
            end else if (pick < 50 && have_mark) begin
               xi = last_x + int'($urandom_range(2)) - 1;
               yi = last_y + int'($urandom_range(2)) - 1;
            end else begin
               xi = int'($urandom_range(ew + 1)) - 1;
               yi = int'($urandom_range(eh + 1)) - 1;
            end
            if (m == MODE_MARK && on_grid(xi, yi, ew, eh)) begin
               have_mark = 1'b1;
               last_x = xi;
               last_y = yi;
            end
            send_item(m, pos_type'(xi), pos_type'(yi), 1'b0, '0);
         end
      end

      wait_idle();
      $display("run covered %0d items: %0d marks, %0d queries, %0d clears",
               n_items, n_marks, n_queries, n_clears);
      $display("%0d results checked over %0d map settings and four idle profiles",
               n_checked, SEGMENTS + 6);
      if (errors == 0) begin
         $display("[grid_path_cost_stamp_map] OK");
      end else begin
         $display("[grid_path_cost_stamp_map] ERROR");
      end
      $finish;
   end

endmodule
